/* design/lpg_pkg.sv */
// Shared constants and types of the line pixel generator.
package lpg_pkg;

   localparam int COORD_BITS    = 6;
   localparam int COLOR_BITS    = 32;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   // One segment as captured from the request channel.
   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      color_type color;
   } seg_type;

   // Walk parameters: major axis from m0 to m1, minor axis starting at n0.
   // Per major step the minor coordinate moves by the whole part
   // (step_up or step_down) plus a carry out of the remainder, which grows by rs.
   typedef struct packed {
      logic      steep;
      coord_type m0;
      coord_type n0;
      coord_type m1;
      coord_type len;
      coord_type rs;
      logic      step_up;
      logic      step_down;
   } setup_type;

endpackage

/* design/line_pixel_generator_top.sv */
// Top level of the line pixel generator: request capture, setup and pixel walker.
//
// The block draws one line segment per request transfer. The req_ channel
// carries both endpoints and a colour word; the rsp_ channel returns one
// transfer per pixel of the segment, walking the major axis one unit at a
// time from the lower to the higher major coordinate, with rsp_tlast set
// on the final pixel. A segment of length L along its major axis yields
// L+1 pixels, at most 64; a zero-length segment yields its single point.
// After a request transfer the block captures the segment, then does its
// setup (axis choice, endpoint ordering, minor step), then emits one pixel
// per cycle from a shared remainder adder while the receiver keeps taking
// them. req_tready is high only while no segment is being walked; it rises
// in the cycle after the final pixel enters the output register, even
// while that pixel still waits to be taken. When rsp_tready is low while
// a pixel is held, the walk pauses and the output register keeps that
// pixel; nothing is dropped. Reset, synchronous and active high, empties
// the output register and returns the sequencer to idle; the segment and
// walk data registers are not reset.
module line_pixel_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_x, start_y, end_x, end_y, pixel_color
   input  logic [lpg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_x, pixel_y, pixel_value
   output logic [lpg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // last_pixel
   output logic                                rsp_tlast
);
   import lpg_pkg::*;

   seg_type   seg_ff, seg_in;
   setup_type setup;
   logic      idle;
   logic      start;

   // A request transfer completes only while the walker is idle.
   assign req_tready = idle;
   assign start      = req_tvalid && req_tready;

   // Fields sit packed from the lowest bit up in the order listed above.
   always_comb begin
      seg_in = seg_ff;
      if (start) begin
         seg_in.start_x = req_tdata[0*COORD_BITS +: COORD_BITS];
         seg_in.start_y = req_tdata[1*COORD_BITS +: COORD_BITS];
         seg_in.end_x   = req_tdata[2*COORD_BITS +: COORD_BITS];
         seg_in.end_y   = req_tdata[3*COORD_BITS +: COORD_BITS];
         seg_in.color   = req_tdata[4*COORD_BITS +: COLOR_BITS];
      end
   end

   // The segment is payload only and needs no reset.
   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   lpg_setup u_setup (
      .seg   (seg_ff),
      .setup (setup)
   );

   lpg_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .setup      (setup),
      .color      (seg_ff.color),
      .idle       (idle),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/lpg_setup.sv */
// Segment setup: axis choice, endpoint ordering and the per-step minor increment.
module lpg_setup (
   input  lpg_pkg::seg_type   seg,
   output lpg_pkg::setup_type setup
);
   import lpg_pkg::*;

   coord_type              adx;
   coord_type              ady;
   logic                   steep;
   coord_type              ma;
   coord_type              na;
   coord_type              mb;
   coord_type              nb;
   logic                   swap;
   coord_type              m0;
   coord_type              n0;
   coord_type              m1;
   coord_type              n1;
   coord_type              len;
   logic signed [COORD_BITS:0] dn;

   always_comb begin
      adx   = (seg.start_x > seg.end_x) ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
      ady   = (seg.start_y > seg.end_y) ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
      steep = adx < ady;

      ma = steep ? seg.start_y : seg.start_x;
      na = steep ? seg.start_x : seg.start_y;
      mb = steep ? seg.end_y   : seg.end_x;
      nb = steep ? seg.end_x   : seg.end_y;

      swap = ma > mb;
      m0   = swap ? mb : ma;
      n0   = swap ? nb : na;
      m1   = swap ? ma : mb;
      n1   = swap ? na : nb;
      len  = m1 - m0;
      dn   = $signed({1'b0, n1}) - $signed({1'b0, n0});

      setup.steep     = steep;
      setup.m0        = m0;
      setup.n0        = n0;
      setup.m1        = m1;
      setup.len       = len;
      setup.step_up   = 1'b0;
      setup.step_down = 1'b0;
      // The minor span never exceeds the major span, so the whole part of dn / len
      // is -1, 0 or +1 and, for a nonzero len, the remainder lies below len.
      if (dn < 0) begin
         setup.step_down = 1'b1;
         setup.rs        = n1 - n0 + len;
      end else if (n1 - n0 == len && len != '0) begin
         setup.step_up = 1'b1;
         setup.rs      = '0;
      end else begin
         setup.rs = n1 - n0;
      end
   end

endmodule

/* design/lpg_walker.sv */
// Pixel walker: sequencer, shared remainder step unit and output register.
module lpg_walker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  lpg_pkg::setup_type                  setup,
   input  lpg_pkg::color_type                  color,
   output logic                                idle,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [lpg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // pixel_x, pixel_y, pixel_value
   output logic                                rsp_tlast   // last_pixel
);
   import lpg_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SETUP = 2'd1;
   localparam logic [1:0] S_RUN   = 2'd2;

   logic [1:0]  state_ff, state_in;
   setup_type   walk_ff, walk_in;
   coord_type   m_ff, m_in;
   coord_type   n_ff, n_in;
   coord_type   r_ff, r_in;
   logic        valid_ff, valid_in;
   coord_type   px_ff, px_in;
   coord_type   py_ff, py_in;
   color_type   value_ff, value_in;
   logic        last_ff, last_in;

   logic                  load;
   logic                  at_end;
   logic [COORD_BITS:0]   sum;
   logic                  wrap;

   assign load   = (state_ff == S_RUN) && (!valid_ff || rsp_tready);
   assign at_end = (m_ff == walk_ff.m1);

   // Shared step unit: remainder add with a single compare and subtract.
   assign sum  = {1'b0, r_ff} + {1'b0, walk_ff.rs};
   assign wrap = sum >= {1'b0, walk_ff.len};

   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      valid_in = valid_ff && !rsp_tready;
      px_in    = px_ff;
      py_in    = py_ff;
      value_in = value_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            walk_in  = setup;
            m_in     = setup.m0;
            n_in     = setup.n0;
            r_in     = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (load) begin
               valid_in = 1'b1;
               px_in    = walk_ff.steep ? n_ff : m_ff;
               py_in    = walk_ff.steep ? m_ff : n_ff;
               value_in = color;
               last_in  = at_end;
               if (at_end) begin
                  state_in = S_IDLE;
               end else begin
                  m_in = m_ff + coord_type'(1);
                  r_in = wrap ? coord_type'(sum - {1'b0, walk_ff.len})
                              : sum[COORD_BITS-1:0];
                  n_in = n_ff + coord_type'(walk_ff.step_up) + coord_type'(wrap)
                         - coord_type'(walk_ff.step_down);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      walk_ff  <= walk_in;
      m_ff     <= m_in;
      n_ff     <= n_in;
      r_ff     <= r_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({value_ff, py_ff, px_ff});
   assign rsp_tlast  = last_ff;

   // Loading the final pixel ends the walk.
   assert property (@(posedge clock) disable iff (reset)
      (load && at_end) |=> (state_ff == S_IDLE))
      else $error("walker did not return to idle after the final pixel");

   // While a segment of nonzero length is walked, the remainder stays below its length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && walk_ff.len != '0) |-> (r_ff < walk_ff.len))
      else $error("remainder out of range");

   // The major coordinate never passes the far endpoint.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (m_ff <= walk_ff.m1))
      else $error("major coordinate overran the segment");

   // A new segment only starts while the walker is idle.
   assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("segment started while a walk was in progress");

endmodule
